// ===== rtl/mec_pkg.sv =====
// Shared types and constants for the Mandelbrot escape counter.
// Q4.28 formats, register indexes and the saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package mec_pkg;

  localparam int CoordW = 10;   // pixel row / column
  localparam int CountW = 9;    // iteration count and limit
  localparam int QW     = 32;   // Q4.28 word
  localparam int StepW  = 31;   // unsigned Q3.28 step
  localparam int ProdW  = 64;   // Q8.56 product
  localparam int WideW  = 66;   // headroom for sums before saturation
  localparam int FracBits = 28;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgRealOrigin    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgImagOrigin    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRealStep      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgImagStep      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgIterationLimit = 3'd4;

  localparam logic signed [QW-1:0] OriginRst = 32'shE000_0000;  // -2.0
  localparam logic [StepW-1:0]     StepRst   = 31'd1493382;
  localparam logic [CountW-1:0]    LimitRst  = 9'd256;

  // 4.0 in Q8.56
  localparam logic [ProdW-1:0] EscapeMag = 64'h0400_0000_0000_0000;

  localparam logic signed [WideW-1:0] SatHi = {{(WideW-QW+1){1'b0}}, {(QW-1){1'b1}}};
  localparam logic signed [WideW-1:0] SatLo = {{(WideW-QW+1){1'b1}}, {(QW-1){1'b0}}};

  function automatic logic signed [QW-1:0] sat_q428(input logic signed [WideW-1:0] v);
    logic signed [QW-1:0] r;
    if (v > SatHi) begin
      r = {1'b0, {(QW-1){1'b1}}};
    end else if (v < SatLo) begin
      r = {1'b1, {(QW-1){1'b0}}};
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/mandelbrot_escape_count_top.sv =====
// Mandelbrot escape-time counter: pixel to c mapping and z = z^2 + c loop.
// Uses mec_pkg; one shared 32x32 signed multiplier under a small sequencer.
// Steps from accept to count valid: S_MRE, S_MIM and S_CIM map c, then each iteration runs S_RR,
// S_II, S_RI (escape test on the last z) and S_UPD; S_FIN loads the count.
// Throughput: one pixel at a time, the next taken the cycle after a count is loaded;
// a new count waits while the output word is not taken. Reset: config defaults, no word.
`timescale 1ns / 1ps

module mandelbrot_escape_count_top
  import mec_pkg::*;
#(
  parameter int MAX_DIM        = 1024,
  parameter int MAX_ITERATIONS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [QW-1:0]       cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CoordW-1:0]   pixel_row_i,
  input  logic [CoordW-1:0]   pixel_col_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CountW-1:0]   escape_count_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MRE  = 4'd1;  // col * real_step
  localparam logic [3:0] S_MIM  = 4'd2;  // row * imag_step, c_re
  localparam logic [3:0] S_CIM  = 4'd3;  // c_im
  localparam logic [3:0] S_RR   = 4'd4;
  localparam logic [3:0] S_II   = 4'd5;
  localparam logic [3:0] S_RI   = 4'd6;  // escape test on re^2 + im^2
  localparam logic [3:0] S_UPD  = 4'd7;  // new z, count++
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_q, state_d;

  logic signed [QW-1:0] real_origin_q, imag_origin_q;
  logic [StepW-1:0]     real_step_q, imag_step_q;
  logic [CountW-1:0]    iteration_limit_q;

  logic [CoordW-1:0]    row_q, col_q;
  logic [CountW-1:0]    limit_q, count_q;
  logic signed [QW-1:0] c_re_q, c_im_q, z_re_q, z_im_q;
  logic signed [ProdW-1:0] p_q, rr_q, ii_q;

  logic                 out_valid_q;
  logic [CountW-1:0]    escape_count_q;

  logic signed [QW-1:0]    mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic signed [ProdW-1:0] diff, re_sh, im_sh;
  logic signed [WideW-1:0] map_re_sum, map_im_sum, nre_sum, nim_sum;
  logic [ProdW-1:0]        mag;
  logic                    escaped, at_limit, out_free;
  logic [CoordW-1:0]       row_sat, col_sat;
  logic [CountW-1:0]       limit_eff;

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign escape_count_o = escape_count_q;
  assign out_free       = !out_valid_q || out_ready_i;

  // index and iteration-limit clamps
  assign row_sat = (int'(pixel_row_i) > MAX_DIM - 1) ? CoordW'(MAX_DIM - 1) : pixel_row_i;
  assign col_sat = (int'(pixel_col_i) > MAX_DIM - 1) ? CoordW'(MAX_DIM - 1) : pixel_col_i;
  assign limit_eff = (int'(iteration_limit_q) > MAX_ITERATIONS) ?
                     CountW'(MAX_ITERATIONS) : iteration_limit_q;

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      S_MRE: begin
        mul_a = {{(QW-CoordW){1'b0}}, col_q};
        mul_b = {1'b0, real_step_q};
      end
      S_MIM: begin
        mul_a = {{(QW-CoordW){1'b0}}, row_q};
        mul_b = {1'b0, imag_step_q};
      end
      S_RR: begin
        mul_a = z_re_q;
        mul_b = z_re_q;
      end
      S_II: begin
        mul_a = z_im_q;
        mul_b = z_im_q;
      end
      default: begin
        mul_a = z_re_q;
        mul_b = z_im_q;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign map_re_sum = {{(WideW-QW){real_origin_q[QW-1]}}, real_origin_q}
                    + {{(WideW-ProdW){p_q[ProdW-1]}}, p_q};
  assign map_im_sum = {{(WideW-QW){imag_origin_q[QW-1]}}, imag_origin_q}
                    + {{(WideW-ProdW){p_q[ProdW-1]}}, p_q};

  // floor shifts: re from Q8.56 difference, im carries the factor of two
  assign diff  = rr_q - ii_q;
  assign re_sh = diff >>> FracBits;
  assign im_sh = p_q >>> (FracBits - 1);
  assign nre_sum = {{(WideW-ProdW){re_sh[ProdW-1]}}, re_sh}
                 + {{(WideW-QW){c_re_q[QW-1]}}, c_re_q};
  assign nim_sum = {{(WideW-ProdW){im_sh[ProdW-1]}}, im_sh}
                 + {{(WideW-QW){c_im_q[QW-1]}}, c_im_q};

  // squares are never negative, so bit 63 is clear
  assign mag     = {1'b0, rr_q[ProdW-2:0]} + {1'b0, p_q[ProdW-2:0]};
  assign escaped = (mag >= EscapeMag);
  assign at_limit = ({1'b0, count_q} + 1'b1) >= {1'b0, limit_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MRE;
      S_MRE:  state_d = S_MIM;
      S_MIM:  state_d = S_CIM;
      S_CIM:  state_d = S_RR;
      S_RR:   state_d = S_II;
      S_II:   state_d = S_RI;
      S_RI:   state_d = escaped ? S_FIN : S_UPD;
      S_UPD:  state_d = at_limit ? S_FIN : S_RR;
      S_FIN:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      real_origin_q     <= OriginRst;
      imag_origin_q     <= OriginRst;
      real_step_q       <= StepRst;
      imag_step_q       <= StepRst;
      iteration_limit_q <= LimitRst;
      out_valid_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgRealOrigin:     real_origin_q     <= cfg_data_i;
          CfgImagOrigin:     imag_origin_q     <= cfg_data_i;
          CfgRealStep:       real_step_q       <= cfg_data_i[StepW-1:0];
          CfgImagStep:       imag_step_q       <= cfg_data_i[StepW-1:0];
          CfgIterationLimit: iteration_limit_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath words, no reset needed
  always_ff @(posedge clk_i) begin
    p_q <= mul_p;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          row_q   <= row_sat;
          col_q   <= col_sat;
          limit_q <= limit_eff;
        end
      end
      S_MIM: begin
        c_re_q  <= sat_q428(map_re_sum);
        z_re_q  <= '0;
        z_im_q  <= '0;
        count_q <= '0;
      end
      S_CIM: c_im_q <= sat_q428(map_im_sum);
      S_II:  rr_q <= p_q;
      S_RI:  ii_q <= p_q;
      S_UPD: begin
        z_re_q  <= sat_q428(nre_sum);
        z_im_q  <= sat_q428(nim_sum);
        count_q <= count_q + 1'b1;
      end
      S_FIN: if (out_free) escape_count_q <= count_q;
      default: ;
    endcase
  end

endmodule

// ===== rtl/mec_checker.sv =====
// Port-level checks for the Mandelbrot escape counter, bound to the top level.
// Uses mec_pkg for field widths.
`timescale 1ns / 1ps

module mec_checker
  import mec_pkg::*;
#(
  parameter int MAX_ITERATIONS = 256
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [CountW-1:0] escape_count_o
);

  // a held word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(escape_count_o))
    else $error("output word changed while stalled");

  // at least one iteration always runs
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> escape_count_o != '0)
    else $error("zero escape count");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(escape_count_o) <= MAX_ITERATIONS)
    else $error("escape count above iteration cap");

  // one pixel in flight: busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second pixel taken during iteration");

endmodule

bind mandelbrot_escape_count_top mec_checker #(
  .MAX_ITERATIONS(MAX_ITERATIONS)
) u_mec_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .escape_count_o (escape_count_o)
);
